/* hw/rtl/assert_macros.svh */
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/rriwp_pkg.sv */
//------------------------------------------------------------------------------
// rriwp_pkg
// Shared types and constants for the round-robin idle worker pool.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package rriwp_pkg;

   localparam int DefMaxWorkers = 16;
   localparam int KeyWidth      = 64;

   localparam logic [2:0] KIND_ADD    = 3'd0;
   localparam logic [2:0] KIND_REMOVE = 3'd1;
   localparam logic [2:0] KIND_GRANT  = 3'd2;
   localparam logic [2:0] KIND_ASSIGN = 3'd3;
   localparam logic [2:0] KIND_IDLE   = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_DUP      = 3'd3;
   localparam logic [2:0] ST_NONEIDLE = 3'd4;

   // One decoded request as it travels from the front to the back.
   typedef struct packed {
      logic [2:0]          kind;
      logic [KeyWidth-1:0] worker_key;
      logic [KeyWidth-1:0] job_key;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic [2:0]          status;
      logic [KeyWidth-1:0] granted_worker;
      logic [KeyWidth-1:0] orphan_job;
      logic                orphan_valid;
      logic                any_idle;
   } rsp_type;

endpackage

/* hw/rtl/round_robin_idle_worker_pool.sv */
//------------------------------------------------------------------------------
// round_robin_idle_worker_pool
// Worker table with add, remove, round-robin idle grant, job assign and idle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

// Requests enter a two-entry queue and are carried out one at a time by a
// table engine that visits one table entry per cycle. An add, remove,
// assign or idle passes through the engine states in order: S_IDLE takes
// it from the queue, S_FIND looks up the id (ending at a hit or at the end
// of the table), S_EXEC acts on it and S_DONE hands the result over. A
// remove that hits goes from S_EXEC to S_SHIFT, which compacts the table
// from the hit slot, before S_DONE. A grant has no lookup; from S_IDLE it
// goes to S_SCAN, a wrapping scan from the cursor for an idle member, and
// then to S_DONE. The finished result sits in an output register, so the
// next item is taken while it waits for pop; a second finished item holds
// the engine until the first one is popped.

module round_robin_idle_worker_pool
   import rriwp_pkg::*;
#(
   parameter int MAX_WORKERS = DefMaxWorkers
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [2:0]          req_kind,
   input  logic [KeyWidth-1:0] req_worker_key,
   input  logic [KeyWidth-1:0] req_job_key,
   output logic                empty,
   input  logic                pop,
   output logic [2:0]          rsp_status,
   output logic [KeyWidth-1:0] rsp_granted_worker,
   output logic [KeyWidth-1:0] rsp_orphan_job,
   output logic                rsp_orphan_valid,
   output logic                rsp_any_idle
);

   cmd_type in_cmd, q_cmd;
   rsp_type rsp;
   logic    q_empty, q_pop;

   assign in_cmd = '{kind: req_kind, worker_key: req_worker_key, job_key: req_job_key};

   rriwp_cmd_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(in_cmd), .full(full),
      .pop(q_pop), .pop_data(q_cmd), .empty(q_empty)
   );

   rriwp_engine #(.MAX_WORKERS(MAX_WORKERS)) u_engine (
      .clock(clock), .reset(reset),
      .cmd_empty(q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
      .rsp_empty(empty), .rsp_pop(pop), .rsp(rsp)
   );

   assign rsp_status         = rsp.status;
   assign rsp_granted_worker = rsp.granted_worker;
   assign rsp_orphan_job     = rsp.orphan_job;
   assign rsp_orphan_valid   = rsp.orphan_valid;
   assign rsp_any_idle       = rsp.any_idle;

endmodule

/* hw/rtl/rriwp_cmd_queue.sv */
//------------------------------------------------------------------------------
// rriwp_cmd_queue
// Two-entry queue that decouples request intake from the table engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module rriwp_cmd_queue
   import rriwp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) mem_ff[wptr_ff] <= push_data;
   end

endmodule

/* hw/rtl/rriwp_engine.sv */
//------------------------------------------------------------------------------
// rriwp_engine
// Table engine: sequences lookup, compaction and idle scan one entry a cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rriwp_engine
   import rriwp_pkg::*;
#(
   parameter int MAX_WORKERS = DefMaxWorkers
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp
);

   localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CW = $clog2(MAX_WORKERS + 1);
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_WORKERS);

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_EXEC, S_SHIFT, S_SCAN, S_DONE
   } state_type;

   state_type           state_ff;
   cmd_type             cmd_ff;
   logic [KeyWidth-1:0] ids_ff  [MAX_WORKERS];
   logic [KeyWidth-1:0] jobs_ff [MAX_WORKERS];
   logic [MAX_WORKERS-1:0] busy_ff, held_ff;
   logic [CW-1:0]       count_ff;
   logic [IW-1:0]       cursor_ff;
   logic [CW-1:0]       idx_ff;     // scan position / step counter
   logic [IW-1:0]       slot_ff;
   logic                hit_ff;
   logic                out_valid_ff;
   rsp_type             work_ff;    // result under construction
   rsp_type             out_ff;     // finished result waiting for pop
   rsp_type             done_rsp;

   logic [IW-1:0] idx_lo, scan_idx, scan_next;
   logic [CW:0]   scan_sum;
   logic [MAX_WORKERS-1:0] member_mask;
   logic          idle_now;

   assign idx_lo = idx_ff[IW-1:0];
   assign scan_sum = (CW+1)'(cursor_ff) + (CW+1)'(idx_ff);
   assign scan_idx = (scan_sum >= {1'b0, count_ff}) ?
                     IW'(scan_sum - {1'b0, count_ff}) : IW'(scan_sum);
   assign scan_next = (CW'(scan_idx) + CW'(1) >= count_ff) ? '0 : IW'(scan_idx + 1'b1);

   always_comb begin
      for (int i = 0; i < MAX_WORKERS; i++) member_mask[i] = (CW'(i) < count_ff);
   end
   assign idle_now = |(member_mask & ~busy_ff);

   always_comb begin
      done_rsp          = work_ff;
      done_rsp.any_idle = idle_now;
   end

   assign cmd_pop   = (state_ff == S_IDLE) && !cmd_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         held_ff      <= '0;
         count_ff     <= '0;
         cursor_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && (!out_valid_ff || rsp_pop)) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff  <= cmd;
                  idx_ff  <= '0;
                  hit_ff  <= 1'b0;
                  work_ff <= '0;
                  if (cmd.kind == KIND_GRANT) state_ff <= S_SCAN;
                  else if (cmd.kind inside {KIND_ADD, KIND_REMOVE, KIND_ASSIGN,
                                            KIND_IDLE}) state_ff <= S_FIND;
                  else state_ff <= S_DONE;
               end
            end
            S_FIND: begin
               if (idx_ff >= count_ff) begin
                  state_ff <= S_EXEC;
               end else if (ids_ff[idx_lo] == cmd_ff.worker_key) begin
                  hit_ff   <= 1'b1;
                  slot_ff  <= idx_lo;
                  state_ff <= S_EXEC;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_EXEC: begin
               state_ff <= (cmd_ff.kind == KIND_REMOVE && hit_ff) ? S_SHIFT : S_DONE;
               case (cmd_ff.kind)
                  KIND_ADD: begin
                     if (hit_ff) work_ff.status <= ST_DUP;
                     else if (count_ff == MaxCnt) work_ff.status <= ST_FULL;
                     else begin
                        ids_ff[count_ff[IW-1:0]]  <= cmd_ff.worker_key;
                        busy_ff[count_ff[IW-1:0]] <= 1'b0;
                        held_ff[count_ff[IW-1:0]] <= 1'b0;
                        count_ff <= count_ff + 1'b1;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!hit_ff) work_ff.status <= ST_NOTFOUND;
                     else begin
                        if (held_ff[slot_ff]) begin
                           work_ff.orphan_job   <= jobs_ff[slot_ff];
                           work_ff.orphan_valid <= 1'b1;
                        end
                        idx_ff <= CW'(slot_ff);
                     end
                  end
                  KIND_ASSIGN: begin
                     if (!hit_ff) work_ff.status <= ST_NOTFOUND;
                     else begin
                        jobs_ff[slot_ff] <= cmd_ff.job_key;
                        held_ff[slot_ff] <= 1'b1;
                     end
                  end
                  KIND_IDLE: begin
                     if (!hit_ff) work_ff.status <= ST_NOTFOUND;
                     else begin
                        busy_ff[slot_ff] <= 1'b0;
                        held_ff[slot_ff] <= 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            S_SHIFT: begin
               if (idx_ff + 1'b1 < count_ff) begin
                  ids_ff[idx_lo]  <= ids_ff[IW'(idx_ff + 1'b1)];
                  jobs_ff[idx_lo] <= jobs_ff[IW'(idx_ff + 1'b1)];
                  busy_ff[idx_lo] <= busy_ff[IW'(idx_ff + 1'b1)];
                  held_ff[idx_lo] <= held_ff[IW'(idx_ff + 1'b1)];
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  busy_ff[IW'(count_ff - 1'b1)] <= 1'b0;
                  held_ff[IW'(count_ff - 1'b1)] <= 1'b0;
                  count_ff <= count_ff - 1'b1;
                  if (slot_ff < cursor_ff) begin
                     if (CW'(cursor_ff - 1'b1) >= count_ff - 1'b1) cursor_ff <= '0;
                     else cursor_ff <= cursor_ff - 1'b1;
                  end else if (CW'(cursor_ff) >= count_ff - 1'b1) begin
                     cursor_ff <= '0;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_SCAN: begin
               if (idx_ff >= count_ff) begin
                  work_ff.status <= ST_NONEIDLE;
                  state_ff       <= S_DONE;
               end else if (!busy_ff[scan_idx]) begin
                  busy_ff[scan_idx]      <= 1'b1;
                  work_ff.granted_worker <= ids_ff[scan_idx];
                  cursor_ff              <= scan_next;
                  state_ff               <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (!out_valid_ff || rsp_pop) begin
                  out_ff   <= done_rsp;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= MaxCnt,
                "member count exceeds table size")
   `ASSERT_IMPL(a_cursor_range, clock, reset, count_ff != '0,
                CW'(cursor_ff) < count_ff, "cursor beyond last member")
   `ASSERT_NEXT(a_done_emits, clock, reset, state_ff == S_DONE && (!out_valid_ff || rsp_pop),
                out_valid_ff, "finished item did not reach the result register")

endmodule
